// File: sv/fwcg_pkg.sv
// fwcg_pkg: shared types and constants of the window coefficient generator
`default_nettype none
package fwcg_pkg;

	typedef enum logic [1:0] {
		WIN_RECT     = 2'd0,
		WIN_HAMMING  = 2'd1,
		WIN_HANN     = 2'd2,
		WIN_BLACKMAN = 2'd3
	} win_t;

	localparam logic REG_TYPE   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	typedef struct packed {
		win_t win;
		logic err;
		logic byp;
	} side_t;

	typedef struct packed {
		logic [29:0] a;
		logic [29:0] x2;
		logic        sel;
		logic        neg;
	} cos_ctx_t;

	localparam int DIV_STAGES   = 8;
	localparam int DIV_BITS     = 4;
	localparam int HORNER_STEPS = 5;
	localparam int COS_LATENCY  = 4 + 3 * HORNER_STEPS + 2;

	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [29:0] Q30_HALF = 30'h2000_0000;

	localparam logic [63:0] RAD_K  = 64'd26986075409;
	localparam logic [16:0] RAD_K0 = 17'(RAD_K & 64'h1_FFFF);
	localparam logic [17:0] RAD_K1 = 18'(RAD_K >> 17);

	localparam logic [30:0] COS_RECIP [HORNER_STEPS] = '{
		31'(((64'd1 << 37) + 64'd89) / 64'd90),
		31'(((64'd1 << 36) + 64'd55) / 64'd56),
		31'(((64'd1 << 35) + 64'd29) / 64'd30),
		31'(((64'd1 << 34) + 64'd11) / 64'd12),
		31'(((64'd1 << 31) + 64'd1) / 64'd2)
	};
	localparam int COS_SHIFT [HORNER_STEPS] = '{37, 36, 35, 34, 31};

	localparam logic [30:0] SIN_RECIP [HORNER_STEPS] = '{
		31'(((64'd1 << 37) + 64'd109) / 64'd110),
		31'(((64'd1 << 37) + 64'd71) / 64'd72),
		31'(((64'd1 << 36) + 64'd41) / 64'd42),
		31'(((64'd1 << 35) + 64'd19) / 64'd20),
		31'(((64'd1 << 33) + 64'd5) / 64'd6)
	};
	localparam int SIN_SHIFT [HORNER_STEPS] = '{37, 37, 36, 35, 33};

	localparam logic signed [39:0] ONE_W     = 40'sd1073741824;
	localparam logic signed [39:0] HAM_BASE  = 40'sd54 * ONE_W;
	localparam logic signed [39:0] HANN_BASE = 40'sd50 * ONE_W;
	localparam logic signed [39:0] BLK_BASE  = 40'sd42 * ONE_W;
	localparam logic signed [39:0] OUT_HALF  = 40'sd1638400;

	localparam logic [20:0] OUT_RECIP = 21'(((64'd1 << 25) + 64'd24) / 64'd25);
	localparam logic [15:0] COEF_ONE  = 16'd32768;

endpackage
`default_nettype wire

// File: sv/fft_window_coefficient_generator.sv
// fft_window_coefficient_generator: symmetric window coefficient pipeline
//
// channel   direction  handshake                      payload
// config    in         psel penable pwrite pready     paddr pwdata prdata
// index     in         in_valid in_ready              sample_index
// result    out        out_valid out_ready            coefficient index_error
//
// one item per cycle while the output skid is empty
// depth set by the 32-bit phase divider (4 bits a stage) and the 5-step horner cosine
// reset clears valid bits, skid flag and registers (type 0, length 4096)
// a full output skid stalls the whole pipeline and drops in_ready
`default_nettype none
module fft_window_coefficient_generator #(
	parameter int MAX_LENGTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] sample_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] coefficient,
	output logic             index_error
);

	localparam int NST   = 1 + fwcg_pkg::DIV_STAGES + fwcg_pkg::COS_LATENCY + 3;
	localparam int NDIV  = fwcg_pkg::DIV_STAGES;
	localparam int DBITS = fwcg_pkg::DIV_BITS;
	localparam int SCOS  = NDIV + fwcg_pkg::COS_LATENCY;
	localparam logic [12:0] LEN_CAP = (MAX_LENGTH > 8191) ? 13'h1FFF : 13'(MAX_LENGTH);

	fwcg_pkg::win_t win_type_q;
	logic [12:0]    win_length_q;
	logic [12:0]    n_eff, d_len;
	logic [31:0]    d_low;
	logic           en, cfg_wr;

	logic [NST-1:0]  vld_s;
	fwcg_pkg::side_t side_s [NST-1];
	logic [12:0]     rem_s1;
	logic [12:0]     rem_d [NDIV];
	logic [31:0]     quo_d [NDIV];

	logic signed [31:0] c1, c2;
	logic signed [39:0] c1w, c2w, wsum, vr;
	logic signed [39:0] wsum_s31;
	logic [40:0]        prod_s32;
	logic               pos_s32;
	logic [15:0]        quo16, coef_next;
	logic [15:0]        coef_s33;
	logic               err_s33;

	logic        skid_full_q;
	logic [15:0] skid_coef_q;
	logic        skid_err_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_type_q   <= fwcg_pkg::WIN_RECT;
			win_length_q <= 13'd4096;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fwcg_pkg::REG_TYPE:   win_type_q   <= fwcg_pkg::win_t'(pwdata[1:0]);
				fwcg_pkg::REG_LENGTH: win_length_q <= pwdata[12:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fwcg_pkg::REG_TYPE:   prdata = {30'd0, win_type_q};
			fwcg_pkg::REG_LENGTH: prdata = {19'd0, win_length_q};
		endcase
	end

	assign n_eff = (win_length_q > LEN_CAP) ? LEN_CAP : win_length_q;
	assign d_len = n_eff - 13'd1;
	assign d_low = {20'd0, d_len[12:1]};

	// flow control
	assign en       = !skid_full_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0].win <= win_type_q;
			side_s[0].err <= {1'b0, sample_index} >= n_eff;
			side_s[0].byp <= (n_eff == 13'd1) || (win_type_q == fwcg_pkg::WIN_RECT);
			rem_s1        <= ({1'b0, sample_index} == d_len) ? 13'd0 : {1'b0, sample_index};
			for (int s = 1; s < NST - 1; s++) begin
				side_s[s] <= side_s[s-1];
			end
		end
	end

	// phase divider: round(i * 2^32 / (n-1)), low 32 quotient bits
	for (genvar g = 0; g < NDIV; g++) begin : g_div
		logic [12:0] r_in;
		logic [31:0] q_in;
		logic [12:0] r_out;
		logic [31:0] q_out;

		if (g == 0) begin : g_first
			assign r_in = rem_s1;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_d[g-1];
			assign q_in = quo_d[g-1];
		end

		always_comb begin
			logic [13:0] r2;
			r_out = r_in;
			q_out = q_in;
			for (int j = 0; j < DBITS; j++) begin
				r2 = {r_out, d_low[5'(31 - DBITS * g - j)]};
				if (r2 >= {1'b0, d_len}) begin
					r2    = r2 - {1'b0, d_len};
					q_out = {q_out[30:0], 1'b1};
				end else begin
					q_out = {q_out[30:0], 1'b0};
				end
				r_out = r2[12:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[g] <= r_out;
				quo_d[g] <= q_out;
			end
		end
	end

	fwcg_cos u_cos1 (
		.clk     (clk),
		.en      (en),
		.phase   (quo_d[NDIV-1]),
		.cos_val (c1)
	);

	fwcg_cos u_cos2 (
		.clk     (clk),
		.en      (en),
		.phase   ({quo_d[NDIV-1][30:0], 1'b0}),
		.cos_val (c2)
	);

	// window sum, scaled by 100 * 2^30
	assign c1w = 40'(c1);
	assign c2w = 40'(c2);

	always_comb begin
		unique case (side_s[SCOS].win)
			fwcg_pkg::WIN_RECT:     wsum = '0;
			fwcg_pkg::WIN_HAMMING:  wsum = fwcg_pkg::HAM_BASE - 40'sd46 * c1w;
			fwcg_pkg::WIN_HANN:     wsum = fwcg_pkg::HANN_BASE - 40'sd50 * c1w;
			fwcg_pkg::WIN_BLACKMAN: wsum = fwcg_pkg::BLK_BASE - 40'sd50 * c1w
				+ 40'sd8 * c2w;
		endcase
	end

	assign vr = wsum_s31 + fwcg_pkg::OUT_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			wsum_s31 <= wsum;
			prod_s32 <= vr[36:17] * fwcg_pkg::OUT_RECIP;
			pos_s32  <= wsum_s31 > 40'sd0;
		end
	end

	assign quo16 = prod_s32[40:25];

	always_comb begin
		priority if (side_s[NST-2].err) begin
			coef_next = '0;
		end else if (side_s[NST-2].byp) begin
			coef_next = fwcg_pkg::COEF_ONE;
		end else if (!pos_s32) begin
			coef_next = '0;
		end else if (quo16 > fwcg_pkg::COEF_ONE) begin
			coef_next = fwcg_pkg::COEF_ONE;
		end else begin
			coef_next = quo16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s33 <= coef_next;
			err_s33  <= side_s[NST-2].err;
		end
	end

	// output skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (vld_s[NST-1] && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld_s[NST-1] && !out_ready) begin
			skid_coef_q <= coef_s33;
			skid_err_q  <= err_s33;
		end
	end

	assign out_valid   = skid_full_q | vld_s[NST-1];
	assign coefficient = skid_full_q ? skid_coef_q : coef_s33;
	assign index_error = skid_full_q ? skid_err_q : err_s33;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> coefficient == 16'd0)
		else $error("error item with nonzero coefficient");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coefficient <= fwcg_pkg::COEF_ONE)
		else $error("coefficient above one");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(vld_s[NST-1] && !out_ready))
		else $error("skid filled without a stalled item");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !out_ready |=> skid_full_q && $stable(skid_coef_q))
		else $error("skid item lost while stalled");

endmodule
`default_nettype wire

// File: sv/fwcg_cos.sv
// fwcg_cos: pipelined cosine of a 32-bit phase turn, signed q30 result
`default_nettype none
module fwcg_cos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [31:0]        phase,
	output logic signed [31:0]      cos_val
);

	localparam int STEPS = fwcg_pkg::HORNER_STEPS;

	logic [29:0] frac;
	logic        hi;
	logic [29:0] rr_s1;
	logic        sel_s1, neg_s1;
	logic [47:0] pa_s2;
	logic [46:0] pb_s2;
	logic        sel_s2, neg_s2;
	logic [64:0] rad_sum;
	logic [29:0] a_s3;
	logic        sel_s3, neg_s3;
	logic [59:0] sq;
	fwcg_pkg::cos_ctx_t ctx_s4;
	fwcg_pkg::cos_ctx_t ctx_a [STEPS];
	fwcg_pkg::cos_ctx_t ctx_b [STEPS];
	fwcg_pkg::cos_ctx_t ctx_c [STEPS];
	logic [29:0] p_h [STEPS];
	logic [60:0] q_h [STEPS];
	logic [30:0] y_h [STEPS];
	logic [60:0] ay;
	logic [30:0] mag_f1;
	logic        neg_f1;

	// octant reduction
	assign frac = phase[29:0];
	assign hi   = frac > fwcg_pkg::Q30_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1  <= hi ? 30'(fwcg_pkg::Q30_ONE - {1'b0, frac}) : frac;
			sel_s1 <= phase[30] ^ hi;
			neg_s1 <= phase[31] ^ phase[30];
		end
	end

	// turn to radians, split constant
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2  <= rr_s1 * fwcg_pkg::RAD_K1;
			pb_s2  <= rr_s1 * fwcg_pkg::RAD_K0;
			sel_s2 <= sel_s1;
			neg_s2 <= neg_s1;
		end
	end

	assign rad_sum = {pa_s2, 17'd0} + {18'd0, pb_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= rad_sum[63:34];
			sel_s3 <= sel_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign sq = a_s3 * a_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4.a   <= a_s3;
			ctx_s4.x2  <= sq[59:30];
			ctx_s4.sel <= sel_s3;
			ctx_s4.neg <= neg_s3;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_horner
		fwcg_pkg::cos_ctx_t ctx_in;
		logic [30:0]        y_in;
		logic [60:0]        xy;

		if (k == 0) begin : g_first
			assign ctx_in = ctx_s4;
			assign y_in   = fwcg_pkg::Q30_ONE;
		end else begin : g_next
			assign ctx_in = ctx_c[k-1];
			assign y_in   = y_h[k-1];
		end

		assign xy = ctx_in.x2 * y_in;

		always_ff @(posedge clk) begin
			if (en) begin
				p_h[k]   <= xy[59:30];
				ctx_a[k] <= ctx_in;
				q_h[k]   <= p_h[k] * (ctx_a[k].sel ? fwcg_pkg::SIN_RECIP[k]
					: fwcg_pkg::COS_RECIP[k]);
				ctx_b[k] <= ctx_a[k];
				y_h[k]   <= fwcg_pkg::Q30_ONE - (ctx_b[k].sel
					? 31'(q_h[k] >> fwcg_pkg::SIN_SHIFT[k])
					: 31'(q_h[k] >> fwcg_pkg::COS_SHIFT[k]));
				ctx_c[k] <= ctx_b[k];
			end
		end
	end

	assign ay = ctx_c[STEPS-1].a * y_h[STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_f1  <= ctx_c[STEPS-1].sel ? ay[60:30] : y_h[STEPS-1];
			neg_f1  <= ctx_c[STEPS-1].neg;
			cos_val <= neg_f1 ? -$signed({1'b0, mag_f1}) : $signed({1'b0, mag_f1});
		end
	end

endmodule
`default_nettype wire

// File: tb/fft_window_coefficient_generator_tb.sv
// fft_window_coefficient_generator_tb: self-checking bench for the window coefficient generator
`timescale 1ns / 100ps
module fft_window_coefficient_generator_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam longint unsigned ONE_Q30  = 64'd1073741824;
	localparam longint unsigned TURN_K   = 64'd26986075409;
	localparam longint          ROUND_DIV = 64'sd3276800;
	localparam logic [2:0] ADDR_TYPE   = 3'(4 * fwcg_pkg::REG_TYPE);
	localparam logic [2:0] ADDR_LENGTH = 3'(4 * fwcg_pkg::REG_LENGTH);

	typedef struct {
		logic [15:0] coef;
		logic        err;
	} coef_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] sample_index;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] coefficient;
	logic        index_error;

	fwcg_pkg::win_t cur_win;
	logic [12:0]    cur_length;
	coef_t          expected_coefs[$];
	int             send_idle_pct;
	int             recv_stall_pct;
	int             idle_count = 0;
	bit             failed = 1'b0;

	fft_window_coefficient_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .sample_index(sample_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.coefficient(coefficient), .index_error(index_error)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned taylor(longint unsigned x, bit is_sin);
		longint unsigned cos_div[5] = '{90, 56, 30, 12, 2};
		longint unsigned sin_div[5] = '{110, 72, 42, 20, 6};
		longint unsigned x2;
		longint unsigned y;
		x2 = q30_mul(x, x);
		y = ONE_Q30;
		for (int k = 0; k < 5; k++)
			y = ONE_Q30 - q30_mul(x2, y) / (is_sin ? sin_div[k] : cos_div[k]);
		return is_sin ? q30_mul(x, y) : y;
	endfunction

	function automatic longint cos_of_turn(logic [31:0] t);
		longint unsigned r;
		longint unsigned a;
		longint unsigned c;
		longint unsigned s;
		r = longint'(t[29:0]);
		if (r <= (ONE_Q30 >> 1)) begin
			a = (r * TURN_K) >> 34;
			c = taylor(a, 0);
			s = taylor(a, 1);
		end else begin
			a = ((ONE_Q30 - r) * TURN_K) >> 34;
			c = taylor(a, 1);
			s = taylor(a, 0);
		end
		case (t[31:30])
			2'd0: return longint'(c);
			2'd1: return -longint'(s);
			2'd2: return -longint'(c);
			default: return longint'(s);
		endcase
	endfunction

	function automatic coef_t window_value(logic [11:0] idx, fwcg_pkg::win_t win,
			logic [12:0] len);
		coef_t res;
		longint unsigned n;
		longint unsigned d;
		logic [31:0] t;
		longint c1;
		longint sum;
		longint unsigned q;
		n = len > 13'd4096 ? 64'd4096 : longint'(len);
		res.err = 0;
		if (longint'(idx) >= n) begin
			res.coef = 0;
			res.err = 1;
			return res;
		end
		if (n == 1 || win == fwcg_pkg::WIN_RECT) begin
			res.coef = fwcg_pkg::COEF_ONE;
			return res;
		end
		d = n - 1;
		t = 32'(((longint'(idx) << 32) + d / 2) / d);
		c1 = cos_of_turn(t);
		case (win)
			fwcg_pkg::WIN_HAMMING: sum = 54 * longint'(ONE_Q30) - 46 * c1;
			fwcg_pkg::WIN_HANN:    sum = 50 * longint'(ONE_Q30) - 50 * c1;
			default:               sum = 42 * longint'(ONE_Q30) - 50 * c1
				+ 8 * cos_of_turn(t * 32'd2);
		endcase
		if (sum <= 0)
			q = 0;
		else
			q = longint'((sum + ROUND_DIV / 2) / ROUND_DIV);
		if (q > 32768)
			q = 32768;
		res.coef = q[15:0];
		return res;
	endfunction

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_window(fwcg_pkg::win_t win, logic [12:0] len);
		reg_write(ADDR_TYPE, 32'(win));
		reg_write(ADDR_LENGTH, 32'(len));
		cur_win = win;
		cur_length = len;
	endtask

	task automatic send_index(logic [11:0] idx);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1;
		sample_index <= idx;
		do @(posedge clk); while (!in_ready);
		expected_coefs.push_back(window_value(idx, cur_win, cur_length));
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_type_extremes();
		for (int w = 0; w < 4; w++) begin
			set_window(fwcg_pkg::win_t'(w), 13'd4096);
			send_index(12'd0);
			send_index(12'd2047);
			send_index(12'd2048);
			send_index(12'd4095);
			wait_drained();
		end
	endtask

	task automatic test_special_lengths();
		set_window(fwcg_pkg::WIN_BLACKMAN, 13'd0);
		send_index(12'd0);
		send_index(12'd4095);
		wait_drained();
		set_window(fwcg_pkg::WIN_HAMMING, 13'd1);
		send_index(12'd0);
		send_index(12'd1);
		wait_drained();
		set_window(fwcg_pkg::WIN_HANN, 13'd2);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd2);
		wait_drained();
		set_window(fwcg_pkg::WIN_BLACKMAN, 13'd3);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd2);
		wait_drained();
		set_window(fwcg_pkg::WIN_BLACKMAN, 13'd8191);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd4095);
		wait_drained();
		set_window(fwcg_pkg::WIN_HANN, 13'd4097);
		send_index(12'd4095);
		wait_drained();
	endtask

	task automatic test_random_windows(int send_pct, int recv_pct, int settings);
		logic [12:0] len;
		logic [11:0] idx;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int s = 0; s < settings; s++) begin
			case ($urandom_range(9))
				0: len = 13'($urandom_range(1));
				1: len = 13'($urandom_range(8191, 4096));
				2: len = 13'($urandom_range(16, 2));
				default: len = 13'($urandom_range(4096, 2));
			endcase
			set_window(fwcg_pkg::win_t'($urandom_range(3)), len);
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(9) == 0 || len == 0)
					idx = 12'($urandom);
				else
					idx = 12'($urandom_range(len > 4096 ? 4095 : len - 1));
				send_index(idx);
				if (s == 0 && k == 50)
					wait_drained();
			end
			wait_drained();
		end
	endtask

	always @(posedge clk) begin
		out_ready <= recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_coefs.size() == 0) begin
				$display("%0t: unexpected item coefficient=%0d index_error=%0b",
					$time, coefficient, index_error);
				failed <= 1;
			end else begin
				if (coefficient !== expected_coefs[0].coef
						|| index_error !== expected_coefs[0].err) begin
					$display("%0t: expected coefficient=%0d index_error=%0b, got %0d %0b",
						$time, expected_coefs[0].coef, expected_coefs[0].err,
						coefficient, index_error);
					failed <= 1;
				end
				void'(expected_coefs.pop_front());
			end
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		sample_index = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_win = fwcg_pkg::WIN_RECT;
		cur_length = 13'd4096;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_index(12'd100);
		wait_drained();
		test_type_extremes();
		test_special_lengths();
		test_random_windows(0, 0, 3);
		test_random_windows(86, 0, 3);
		test_random_windows(0, 86, 3);
		test_random_windows(14, 14, 3);
		if (!failed)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
